// File: src/spa_pkg.sv
// Shared types, constants and codes for the surface pixel to ARGB converter.
`default_nettype none
package spa_pkg;

  localparam int unsigned PALETTE_DEPTH_DEF = 256;
  localparam int unsigned PIX_W             = 32;
  localparam int unsigned SLOT_W            = 8;
  localparam int unsigned COLOR_W           = 32;
  localparam int unsigned ARGB_W            = 32;
  localparam int unsigned CFG_W             = 32;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned SHIFT_W           = 5;
  localparam int unsigned LOSS_W            = 3;
  localparam int unsigned SHIFTS_W          = 4 * SHIFT_W;
  localparam int unsigned LOSSES_W          = 4 * LOSS_W;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_PIXEL_MODE     = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_RED_MASK       = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_GREEN_MASK     = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_BLUE_MASK      = cfg_idx_t'(3);
  localparam cfg_idx_t CFG_ALPHA_MASK     = cfg_idx_t'(4);
  localparam cfg_idx_t CFG_CHANNEL_SHIFTS = cfg_idx_t'(5);
  localparam cfg_idx_t CFG_CHANNEL_LOSSES = cfg_idx_t'(6);

  localparam logic CMD_CONVERT       = 1'b0;
  localparam logic CMD_PALETTE_WRITE = 1'b1;

  localparam logic MODE_DIRECT  = 1'b0;
  localparam logic MODE_PALETTE = 1'b1;

  localparam logic [PIX_W-1:0] RED_MASK_RST   = 32'h00FF_0000;
  localparam logic [PIX_W-1:0] GREEN_MASK_RST = 32'h0000_FF00;
  localparam logic [PIX_W-1:0] BLUE_MASK_RST  = 32'h0000_00FF;
  localparam logic [PIX_W-1:0] ALPHA_MASK_RST = 32'h0000_0000;

  typedef struct packed {
    logic                pixel_mode;
    logic [PIX_W-1:0]    red_mask;
    logic [PIX_W-1:0]    green_mask;
    logic [PIX_W-1:0]    blue_mask;
    logic [PIX_W-1:0]    alpha_mask;
    logic [SHIFTS_W-1:0] channel_shifts;
    logic [LOSSES_W-1:0] channel_losses;
  } cfg_t;

endpackage
`default_nettype wire

// File: src/spa_in_if.sv
// Input channel: convert or palette-write words.
`default_nettype none
interface spa_in_if;
  import spa_pkg::*;

  logic               valid;
  logic               ready;
  logic               cmd;
  logic [PIX_W-1:0]   pixel_word;
  logic [SLOT_W-1:0]  palette_slot;
  logic [COLOR_W-1:0] palette_color;

  modport source (output valid, output cmd, output pixel_word, output palette_slot,
                  output palette_color, input ready);
  modport sink   (input valid, input cmd, input pixel_word, input palette_slot,
                  input palette_color, output ready);
endinterface
`default_nettype wire

// File: src/spa_out_if.sv
// Result channel: converted ARGB8888 words.
`default_nettype none
interface spa_out_if;
  import spa_pkg::*;

  logic              valid;
  logic              ready;
  logic [ARGB_W-1:0] argb_pixel;

  modport source (output valid, output argb_pixel, input ready);
  modport sink   (input valid, input argb_pixel, output ready);
endinterface
`default_nettype wire

// File: src/surface_pixel_to_argb.sv
// Top level: surface pixel to ARGB8888 converter with palette store.
// A convert word is registered in the read stage and then in the output register before it shows on the output.
// Throughput: one word per cycle unless the output stalls; the palette RAM takes one read and one write a cycle.
// A palette write takes effect for a convert accepted on the next cycle; it yields no result.
// Reset (synchronous, rst_n low) restores register defaults and clears every palette
// entry's valid bit at once; an unwritten entry reads as zero. No clearing pass.
`default_nettype none
module surface_pixel_to_argb #(
  parameter int unsigned PALETTE_DEPTH = spa_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire spa_pkg::cfg_idx_t             cfg_addr,
  input  wire logic [spa_pkg::CFG_W-1:0]     cfg_wdata,
  spa_in_if.sink                             in_chan,
  spa_out_if.source                          out_chan
);
  import spa_pkg::*;

  localparam int unsigned IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_mode     <= MODE_DIRECT;
      cfg_r.red_mask       <= RED_MASK_RST;
      cfg_r.green_mask     <= GREEN_MASK_RST;
      cfg_r.blue_mask      <= BLUE_MASK_RST;
      cfg_r.alpha_mask     <= ALPHA_MASK_RST;
      cfg_r.channel_shifts <= '0;
      cfg_r.channel_losses <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PIXEL_MODE:     cfg_r.pixel_mode     <= cfg_wdata[0];
        CFG_RED_MASK:       cfg_r.red_mask       <= cfg_wdata[PIX_W-1:0];
        CFG_GREEN_MASK:     cfg_r.green_mask     <= cfg_wdata[PIX_W-1:0];
        CFG_BLUE_MASK:      cfg_r.blue_mask      <= cfg_wdata[PIX_W-1:0];
        CFG_ALPHA_MASK:     cfg_r.alpha_mask     <= cfg_wdata[PIX_W-1:0];
        CFG_CHANNEL_SHIFTS: cfg_r.channel_shifts <= cfg_wdata[SHIFTS_W-1:0];
        CFG_CHANNEL_LOSSES: cfg_r.channel_losses <= cfg_wdata[LOSSES_W-1:0];
        default: ;
      endcase
    end
  end

  logic in_acc, s1_adv;
  logic s1_valid_r, s1_mode_r, s1_hit_r, s1_alpha_en_r;
  logic [ARGB_W-1:0] s1_direct_r;
  logic out_valid_r;
  logic [ARGB_W-1:0] out_argb_r, out_argb_nxt;

  assign s1_adv        = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // palette addressing
  logic [IDX_W-1:0] wr_idx, rd_idx;
  logic             wr_in_range, rd_in_range, pal_we;
  logic [PALETTE_DEPTH-1:0] pal_vld_r;
  logic [COLOR_W-1:0] pal_rdata;

  assign wr_idx      = in_chan.palette_slot[IDX_W-1:0];
  assign rd_idx      = in_chan.pixel_word[IDX_W-1:0];
  assign wr_in_range = {1'b0, in_chan.palette_slot} < (SLOT_W+1)'(PALETTE_DEPTH);
  assign rd_in_range = {1'b0, in_chan.pixel_word[SLOT_W-1:0]} < (SLOT_W+1)'(PALETTE_DEPTH);
  assign pal_we      = in_acc && (in_chan.cmd == CMD_PALETTE_WRITE) && wr_in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_vld_r <= '0;
    end else if (pal_we) begin
      pal_vld_r[wr_idx] <= 1'b1;
    end
  end

  spa_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (wr_idx),
    .wdata (in_chan.palette_color),
    .re    (in_acc),
    .raddr (rd_idx),
    .rdata (pal_rdata)
  );

  logic [ARGB_W-1:0] direct_argb;

  spa_unpack u_unpack (
    .cfg  (cfg_r),
    .pix  (in_chan.pixel_word),
    .argb (direct_argb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= (in_chan.cmd == CMD_CONVERT);
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r     <= cfg_r.pixel_mode;
      s1_hit_r      <= rd_in_range && pal_vld_r[rd_idx];
      s1_alpha_en_r <= (cfg_r.alpha_mask != '0);
      s1_direct_r   <= direct_argb;
    end
  end

  always_comb begin
    if (s1_mode_r == MODE_PALETTE) begin
      if (s1_hit_r) begin
        out_argb_nxt = {(s1_alpha_en_r ? pal_rdata[31:24] : 8'h00), pal_rdata[23:0]};
      end else begin
        out_argb_nxt = '0;
      end
    end else begin
      out_argb_nxt = s1_direct_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_argb_r <= out_argb_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.argb_pixel = out_argb_r;

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.cmd == CMD_PALETTE_WRITE) |=> !s1_valid_r)
    else $error("palette write produced a pending result");

  a_reset_clears_palette: assert property (@(posedge clk)
    $past(!rst_n) |-> (pal_vld_r == '0))
    else $error("palette valid bits not cleared by reset");

  a_rdata_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> $stable(pal_rdata))
    else $error("palette read data lost while stalled");

  a_skid_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_chan.ready)
    else $error("input stalled with empty read stage");

  a_miss_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv && s1_mode_r == MODE_PALETTE && !s1_hit_r) |=> (out_argb_r == '0))
    else $error("unwritten palette entry did not read as zero");

endmodule
`default_nettype wire

// File: src/spa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module spa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: src/spa_unpack.sv
// Direct-mode channel unpack: mask, shift down, expand, pack to ARGB8888.
`default_nettype none
module spa_unpack (
  input  wire spa_pkg::cfg_t               cfg,
  input  wire logic [spa_pkg::PIX_W-1:0]   pix,
  output logic      [spa_pkg::ARGB_W-1:0]  argb
);
  import spa_pkg::*;

  function automatic logic [7:0] unpack_chan(input logic [PIX_W-1:0]   p,
                                             input logic [PIX_W-1:0]   mask,
                                             input logic [SHIFT_W-1:0] sh,
                                             input logic [LOSS_W-1:0]  ls);
    logic [PIX_W-1:0] t;
    t = (p & mask) >> sh;
    t = t << ls;
    return t[7:0];
  endfunction

  logic [7:0] red, green, blue, alpha;

  always_comb begin
    red   = unpack_chan(pix, cfg.red_mask,   cfg.channel_shifts[4:0],   cfg.channel_losses[2:0]);
    green = unpack_chan(pix, cfg.green_mask, cfg.channel_shifts[9:5],   cfg.channel_losses[5:3]);
    blue  = unpack_chan(pix, cfg.blue_mask,  cfg.channel_shifts[14:10], cfg.channel_losses[8:6]);
    alpha = unpack_chan(pix, cfg.alpha_mask, cfg.channel_shifts[19:15], cfg.channel_losses[11:9]);
    argb  = {((cfg.alpha_mask != '0) ? alpha : 8'h00), red, green, blue};
  end

endmodule
`default_nettype wire
